// File: sv/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, codes and constants of the focus-session timer.
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BREAK_MIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_BREAK_MIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYPER_CAP_MIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_GRACE_SEC = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOAST_TIMEOUT  = 3'd4;

   localparam logic [7:0] RST_BREAK_MIN      = 8'd5;
   localparam logic [7:0] RST_LONG_BREAK_MIN = 8'd15;
   localparam logic [7:0] RST_HYPER_CAP_MIN  = 8'd30;
   localparam logic [7:0] RST_IDLE_GRACE_SEC = 8'd30;
   localparam logic [7:0] RST_TOAST_TIMEOUT  = 8'd30;

   localparam int SEC_W = 14;

   localparam logic [SEC_W-1:0] SEC_PER_MIN = 14'd60;
   localparam logic [8:0]       FULL_ARC    = 9'd360;
   localparam logic [13:0]      XP_BASE     = 14'd50;
   localparam logic [13:0]      XP_PER_MIN  = 14'd5;
   localparam logic [12:0]      XP_MAX      = 13'h1FFF;
   localparam logic [16:0]      XP_NUM_MAX  = 17'h1FFFF;

   // minutes from seconds: multiply by the reciprocal of 60, exact below 2^17
   localparam logic [17:0]      XP_RECIP       = 18'd139811;
   localparam int               XP_RECIP_SHIFT = 23;
   localparam int               XP_PROD_W      = 35;
   localparam int               XP_MIN_W       = 12;

   // divider: quotient of at most QUO_W bits, numerator below 2^NUM_W
   localparam int DIV_NUM_W = 23;
   localparam int DIV_DEN_W = SEC_W;
   localparam int DIV_QUO_W = 12;
   localparam int DIV_CNT_W = 4;
   localparam int DIV_DSH_W = DIV_DEN_W + DIV_QUO_W;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_BREAK  = 3'd2,
      CMD_PAUSE  = 3'd3,
      CMD_RESUME = 3'd4,
      CMD_STOP   = 3'd5
   } fst_cmd_code_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_TICK,
      OP_START,
      OP_BREAK,
      OP_PAUSE,
      OP_RESUME,
      OP_STOP
   } fst_op_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_FOCUS = 3'd1,
      MODE_HYPER = 3'd2,
      MODE_BREAK = 3'd3,
      MODE_AWAY  = 3'd4
   } fst_mode_type;

   typedef enum logic [1:0] {
      MOT_NONE   = 2'd0,
      MOT_RUN    = 2'd1,
      MOT_HOLD   = 2'd2,
      MOT_RETURN = 2'd3
   } fst_motor_type;

   typedef enum logic [1:0] {
      BK_WAIT,
      BK_LOAD,
      BK_DIV,
      BK_DONE
   } fst_back_state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] planned_minutes;
      logic [7:0] cycle_count;
   } fst_req_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  motor_command;
      logic [13:0] motor_seconds;
      logic [13:0] remaining_sec;
      logic [15:0] overflow_sec;
      logic [13:0] break_left_sec;
      logic [8:0]  base_arc_deg;
      logic [8:0]  overflow_arc_deg;
      logic        toast_on;
      logic        session_running;
      logic [12:0] xp_award;
      logic        spoon_return;
   } fst_rsp_type;

   typedef struct packed {
      fst_op_type op;
      logic [7:0] planned_minutes;
      logic [7:0] cycle_count;
   } fst_cmd_type;

   typedef struct packed {
      logic [7:0] break_minutes;
      logic [7:0] long_break_minutes;
      logic [7:0] overflow_cap_min;
      logic [7:0] idle_grace_sec;
      logic [7:0] toast_timeout_sec;
   } fst_cfg_type;

endpackage

// File: sv/fst_front.sv
// ----------------------------------------------------------------------------
// fst_front
// Takes request words, decodes the command and queues it for the back end.
// ----------------------------------------------------------------------------
module fst_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fst_pkg::fst_req_type req_data,
   output logic                q_valid,
   output fst_pkg::fst_cmd_type q_head,
   input  logic                q_pop
);
   import fst_pkg::*;

   fst_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   fst_cmd_type decoded;
   logic        push;

   always_comb begin
      decoded.planned_minutes = req_data.planned_minutes;
      decoded.cycle_count     = req_data.cycle_count;
      case (req_data.command)
         CMD_TICK:   decoded.op = OP_TICK;
         CMD_START:  decoded.op = OP_START;
         CMD_BREAK:  decoded.op = OP_BREAK;
         CMD_PAUSE:  decoded.op = OP_PAUSE;
         CMD_RESUME: decoded.op = OP_RESUME;
         CMD_STOP:   decoded.op = OP_STOP;
         default:    decoded.op = OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: sv/fst_div.sv
// ----------------------------------------------------------------------------
// fst_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fst_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fst_pkg::DIV_NUM_W-1:0]   num,
   input  logic [fst_pkg::DIV_DEN_W-1:0]   den,
   output logic                            busy,
   output logic [fst_pkg::DIV_QUO_W-1:0]   quot
);
   import fst_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_DSH_W-1:0] dsh_ff, dsh_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic                 ge;

   assign ge   = {{(DIV_DSH_W-DIV_NUM_W){1'b0}}, rem_ff} >= dsh_ff;
   assign busy = busy_ff;
   assign quot = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_QUO_W - 1);
         rem_in  = num;
         dsh_in  = DIV_DSH_W'({den, {(DIV_QUO_W-1){1'b0}}});
         quo_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
         cnt_in = cnt_ff - 1'b1;
         if (ge) begin
            rem_in = rem_ff - dsh_ff[DIV_NUM_W-1:0];
         end
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[DIV_QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

endmodule

// File: sv/fst_back.sv
// ----------------------------------------------------------------------------
// fst_back
// Session state machine: applies one queued command, runs the arc division
// and fills the result register.
// ----------------------------------------------------------------------------
module fst_back #(
   parameter int COUNT_WIDTH = fst_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fst_pkg::fst_cfg_type  cfg,
   input  logic                 q_valid,
   input  fst_pkg::fst_cmd_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fst_pkg::fst_rsp_type  rsp_data
);
   import fst_pkg::*;

   localparam int CW = COUNT_WIDTH;

   fst_back_state_type st_ff, st_in;
   fst_mode_type       mode_ff, mode_in;
   fst_motor_type      mot_ff, mot_in;
   logic [SEC_W-1:0]   planned_ff, planned_in;
   logic [CW-1:0]      elapsed_ff, elapsed_in;
   logic [CW-1:0]      break_ff, break_in;
   logic [CW-1:0]      away_ff, away_in;
   logic               toast_ff, toast_in;
   logic [7:0]         age_ff, age_in;
   logic               running_ff, running_in;
   logic               reward_ff, reward_in;
   logic [16:0]        xpnum_ff, xpnum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fst_rsp_type        rsp_ff, rsp_in;

   logic                 div_start, div_busy, rsp_load;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_QUO_W-1:0] div_quot;

   logic [CW-1:0]    planned_ext, inc_e, inc_b, inc_a, ovf_next, ovf;
   logic [SEC_W-1:0] cap60;
   logic             lt, ovf_ge_cap;
   logic [7:0]       mins;

   assign planned_ext = CW'(planned_ff);
   assign cap60       = SEC_W'(cfg.overflow_cap_min) * SEC_PER_MIN;
   assign inc_e       = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign inc_b       = (break_ff == '1) ? break_ff : break_ff + 1'b1;
   assign inc_a       = (away_ff == '1) ? away_ff : away_ff + 1'b1;
   assign ovf_next    = (inc_e > planned_ext) ? inc_e - planned_ext : '0;
   assign ovf         = (elapsed_ff > planned_ext) ? elapsed_ff - planned_ext : '0;
   assign lt          = elapsed_ff < planned_ext;
   assign ovf_ge_cap  = ovf >= CW'(cap60);

   // command execution
   always_comb begin
      mode_in    = mode_ff;
      mot_in     = mot_ff;
      planned_in = planned_ff;
      elapsed_in = elapsed_ff;
      break_in   = break_ff;
      away_in    = away_ff;
      toast_in   = toast_ff;
      age_in     = age_ff;
      running_in = running_ff;
      reward_in  = reward_ff;
      xpnum_in   = xpnum_ff;
      mins       = cfg.break_minutes;
      if (q_pop) begin
         mot_in    = MOT_NONE;
         reward_in = 1'b0;
         case (q_head.op)
            OP_TICK: begin
               if (mode_ff != MODE_IDLE) begin
                  if (toast_ff) begin
                     age_in = (age_ff == 8'hFF) ? age_ff : age_ff + 1'b1;
                  end
                  if (mode_ff == MODE_FOCUS || mode_ff == MODE_HYPER) begin
                     elapsed_in = inc_e;
                     if (mode_ff == MODE_FOCUS && inc_e >= planned_ext) begin
                        mode_in  = MODE_HYPER;
                        mot_in   = MOT_RUN;
                        toast_in = 1'b1;
                        age_in   = 8'd0;
                     end else if (mode_ff == MODE_HYPER) begin
                        if (ovf_next >= CW'(cap60)) begin
                           toast_in = 1'b0;
                           mode_in  = MODE_BREAK;
                           break_in = '0;
                           mot_in   = MOT_HOLD;
                        end
                        if (toast_in && age_in >= cfg.toast_timeout_sec) begin
                           toast_in = 1'b0;
                        end
                     end
                  end else if (mode_ff == MODE_BREAK) begin
                     break_in = inc_b;
                     if ({1'b0, inc_b} >= (CW+1)'(planned_ff) + (CW+1)'(cfg.idle_grace_sec))
                     begin
                        mode_in = MODE_AWAY;
                        away_in = '0;
                        mot_in  = MOT_HOLD;
                     end
                  end else begin
                     away_in = inc_a;
                  end
               end
            end
            OP_START: begin
               planned_in = SEC_W'(q_head.planned_minutes) * SEC_PER_MIN;
               elapsed_in = '0;
               break_in   = '0;
               away_in    = '0;
               toast_in   = 1'b0;
               age_in     = 8'd0;
               running_in = 1'b1;
               mode_in    = MODE_FOCUS;
               mot_in     = MOT_RUN;
            end
            OP_BREAK: begin
               if (mode_ff == MODE_FOCUS || mode_ff == MODE_HYPER) begin
                  if (q_head.cycle_count != 8'd0 && q_head.cycle_count[1:0] == 2'b00) begin
                     mins = cfg.long_break_minutes;
                  end
                  toast_in   = 1'b0;
                  planned_in = SEC_W'(mins) * SEC_PER_MIN;
                  mode_in    = MODE_BREAK;
                  break_in   = '0;
                  mot_in     = MOT_HOLD;
               end
            end
            OP_PAUSE: begin
               if (mode_ff == MODE_FOCUS || mode_ff == MODE_HYPER) begin
                  mode_in = MODE_AWAY;
                  away_in = '0;
                  mot_in  = MOT_HOLD;
               end
            end
            OP_RESUME: begin
               if (mode_ff == MODE_AWAY || mode_ff == MODE_BREAK) begin
                  mode_in = lt ? MODE_FOCUS : MODE_HYPER;
                  mot_in  = MOT_RUN;
               end
            end
            OP_STOP: begin
               if (mode_ff != MODE_IDLE) begin
                  reward_in  = (mode_ff != MODE_AWAY);
                  xpnum_in   = ((CW+17)'(elapsed_ff) > (CW+17)'(XP_NUM_MAX)) ?
                               XP_NUM_MAX : 17'(elapsed_ff);
                  planned_in = '0;
                  elapsed_in = '0;
                  break_in   = '0;
                  away_in    = '0;
                  toast_in   = 1'b0;
                  age_in     = 8'd0;
                  running_in = 1'b0;
                  mode_in    = MODE_IDLE;
                  mot_in     = MOT_RETURN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // divider operands
   always_comb begin
      div_num = '0;
      div_den = SEC_W'(1);
      if ((mode_ff == MODE_FOCUS || mode_ff == MODE_AWAY) && lt) begin
         div_num = DIV_NUM_W'(elapsed_ff[SEC_W-1:0]) * DIV_NUM_W'(FULL_ARC);
         div_den = planned_ff;
      end else if (mode_ff == MODE_HYPER && !ovf_ge_cap) begin
         div_num = DIV_NUM_W'(ovf[SEC_W-1:0]) * DIV_NUM_W'(FULL_ARC);
         div_den = cap60;
      end
   end

   fst_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // result assembly
   logic [8:0]           base_a;
   logic [CW:0]          away2;
   logic [13:0]          xp_full;
   logic [XP_PROD_W-1:0] xp_prod;
   logic [XP_MIN_W-1:0]  xp_mins;

   always_comb begin
      away2   = {away_ff, 1'b0};
      base_a  = lt ? div_quot[8:0] : FULL_ARC;
      xp_prod = XP_PROD_W'(xpnum_ff) * XP_PROD_W'(XP_RECIP);
      xp_mins = xp_prod[XP_RECIP_SHIFT +: XP_MIN_W];
      xp_full = XP_BASE + XP_PER_MIN * 14'(xp_mins);

      rsp_in.mode          = mode_ff;
      rsp_in.motor_command = mot_ff;
      rsp_in.motor_seconds = (mot_ff == MOT_RUN) ? planned_ff : '0;
      rsp_in.remaining_sec = lt ? planned_ff - elapsed_ff[SEC_W-1:0] : '0;
      rsp_in.overflow_sec  = ((CW+16)'(ovf) > (CW+16)'(16'hFFFF)) ? 16'hFFFF : 16'(ovf);
      rsp_in.break_left_sec = (CW'(planned_ff) > break_ff) ?
                              planned_ff - break_ff[SEC_W-1:0] : '0;
      if (planned_ff == '0) begin
         rsp_in.base_arc_deg = '0;
      end else if (mode_ff == MODE_AWAY) begin
         rsp_in.base_arc_deg = ((CW+1)'(base_a) > away2) ? base_a - away2[8:0] : '0;
      end else if (mode_ff == MODE_FOCUS) begin
         rsp_in.base_arc_deg = base_a;
      end else begin
         rsp_in.base_arc_deg = FULL_ARC;
      end
      if (mode_ff == MODE_HYPER && cap60 != '0) begin
         rsp_in.overflow_arc_deg = ovf_ge_cap ? FULL_ARC : div_quot[8:0];
      end else begin
         rsp_in.overflow_arc_deg = '0;
      end
      rsp_in.toast_on        = toast_ff;
      rsp_in.session_running = running_ff;
      if (reward_ff) begin
         rsp_in.xp_award = (xp_full > 14'(XP_MAX)) ? XP_MAX : xp_full[12:0];
      end else begin
         rsp_in.xp_award = '0;
      end
      rsp_in.spoon_return = reward_ff;
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_WAIT: if (q_valid) st_in = BK_LOAD;
         BK_LOAD: st_in = BK_DIV;
         BK_DIV:  if (!div_busy) st_in = BK_DONE;
         BK_DONE: if (!rsp_valid_ff || rsp_ready) st_in = BK_WAIT;
         default: st_in = BK_WAIT;
      endcase
   end

   always_comb begin
      q_pop     = (st_ff == BK_WAIT) && q_valid;
      div_start = (st_ff == BK_LOAD);
      rsp_load  = (st_ff == BK_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_WAIT;
         mode_ff      <= MODE_IDLE;
         mot_ff       <= MOT_NONE;
         planned_ff   <= '0;
         elapsed_ff   <= '0;
         break_ff     <= '0;
         away_ff      <= '0;
         toast_ff     <= 1'b0;
         age_ff       <= 8'd0;
         running_ff   <= 1'b0;
         reward_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         mode_ff      <= mode_in;
         mot_ff       <= mot_in;
         planned_ff   <= planned_in;
         elapsed_ff   <= elapsed_in;
         break_ff     <= break_in;
         away_ff      <= away_in;
         toast_ff     <= toast_in;
         age_ff       <= age_in;
         running_ff   <= running_in;
         reward_ff    <= reward_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xpnum_ff <= xpnum_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: sv/focus_session_timer.sv
// ----------------------------------------------------------------------------
// focus_session_timer
// Focus-session timer: commands in, one status word out per command.
// ----------------------------------------------------------------------------
// Each command word yields exactly one result word. In the back end a
// command passes through the states BK_WAIT, which pops and applies it, BK_LOAD,
// which starts the divider, BK_DIV, which waits for the 12 quotient bits of the shared
// one-bit-a-cycle divider that produces the arc angle, and BK_DONE, which loads
// the result once the result register is free. Only then does the next
// command leave the queue. The points figure comes from a reciprocal
// multiply. A two-word queue in front lets commands be taken while the
// back end is busy, and the result register holds its word until taken.
// Configuration writes take effect at once and should only be made while
// no command is in flight.
module focus_session_timer #(
   parameter int COUNT_WIDTH = fst_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fst_pkg::fst_req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fst_pkg::fst_rsp_type               rsp_data,
   input  logic                              csr_write_en,
   input  logic [fst_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fst_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fst_pkg::*;

   fst_cfg_type cfg_ff, cfg_in;
   fst_cmd_type q_head;
   logic        q_valid, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BREAK_MIN:      cfg_in.break_minutes      = csr_wdata;
            CSR_LONG_BREAK_MIN: cfg_in.long_break_minutes = csr_wdata;
            CSR_HYPER_CAP_MIN:  cfg_in.overflow_cap_min   = csr_wdata;
            CSR_IDLE_GRACE_SEC: cfg_in.idle_grace_sec     = csr_wdata;
            CSR_TOAST_TIMEOUT:  cfg_in.toast_timeout_sec  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.break_minutes      <= RST_BREAK_MIN;
         cfg_ff.long_break_minutes <= RST_LONG_BREAK_MIN;
         cfg_ff.overflow_cap_min   <= RST_HYPER_CAP_MIN;
         cfg_ff.idle_grace_sec     <= RST_IDLE_GRACE_SEC;
         cfg_ff.toast_timeout_sec  <= RST_TOAST_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   fst_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
